// ===== rtl/core/mahc_pkg.sv =====
package mahc_pkg;

  // result status codes
  localparam logic [2:0] ST_NO_CRC    = 3'd0;
  localparam logic [2:0] ST_CRC_OK    = 3'd1;
  localparam logic [2:0] ST_CRC_BAD   = 3'd2;
  localparam logic [2:0] ST_BAD_HDR   = 3'd3;
  localparam logic [2:0] ST_SIZE_UNK  = 3'd4;
  localparam logic [2:0] ST_PROT_UNK  = 3'd5;

  localparam logic [15:0] CRC_POLY = 16'h8005;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // what the back end has to do with a queued entry
  typedef enum logic [1:0] {
    KIND_PLAIN    = 2'd0,  // emit, frame length is zero
    KIND_LEN_EMIT = 2'd1,  // compute frame length, then emit
    KIND_LEN      = 2'd2,  // compute frame length and keep it
    KIND_CRC      = 2'd3   // emit CRC verdict with kept frame length
  } mahc_kind_t;

  typedef struct packed {
    mahc_kind_t  kind;
    logic [2:0]  status;
    logic [5:0]  prot_len;
    logic [15:0] crc;
    logic [31:0] header;
  } mahc_entry_t;

  typedef enum logic [2:0] {
    BK_IDLE = 3'd0,
    BK_NUM  = 3'd1,
    BK_PROD = 3'd2,
    BK_FIX  = 3'd3,
    BK_EMIT = 3'd4
  } mahc_bk_state_t;

endpackage

// ===== rtl/core/mpeg_audio_frame_header_crc_check.sv =====
// MPEG audio frame header decode and CRC-16 check.
//
// Input channel: one frame byte per beat on in_tdata, in_tuser high on the
// first header byte of a frame. Bytes before the first start, or after a
// frame's result, are dropped until the next start; a start in mid-frame
// abandons the frame under way without a result.
// Result channel: one beat per frame with status, frame length, protected
// length, computed CRC and the header word.
// cfg_wr_en / cfg_wr_data set the CRC check enable (reset value 1); write it
// only while no frame is in flight.
//
// Throughput: one byte per cycle while the two-entry queue between front end
// and back end has room. The back end takes a header through these steps in
// order: take, numerator, reciprocal multiply, one correction step.
// Reset empties the queue, clears the output valid flag and leaves the front end
// waiting for a start. When the receiver stalls, the result holds in the output
// register, the back end waits, and in_tready falls once the queue fills.
module mpeg_audio_frame_header_crc_check (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tuser,    // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [14:3] frame_bytes, [20:15] protected_bytes,
  // [36:21] computed_crc, [68:37] header_word, [71:69] zero
  output logic [71:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data  // crc_check_enable
);
  import mahc_pkg::*;

  logic        crc_en_r;
  logic        q_push, q_pop, q_full, q_valid;
  mahc_entry_t q_in, q_head;

  // hold the check enable between writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_en_r <= 1'b1;
    end else if (cfg_wr_en) begin
      crc_en_r <= cfg_wr_data;
    end
  end

  // front end: track byte position, gather header, run CRC, classify
  mahc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .crc_en    (crc_en_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  // decouple the byte stream from the length computation
  mahc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_in),
    .pop        (q_pop),
    .full       (q_full),
    .valid      (q_valid),
    .head       (q_head)
  );

  // back end: frame length, result assembly and output register
  mahc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== rtl/core/mahc_front.sv =====
module mahc_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               crc_en,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] data_byte
  input  logic               in_tuser,   // [0] frame_start
  input  logic               q_full,
  output logic               q_push,
  output mahc_pkg::mahc_entry_t q_entry
);
  import mahc_pkg::*;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      if (c[15] != b[i]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  logic [5:0]  pos_r, pos_nxt, pos_cur;
  logic [31:0] hdr_r, hdr_nxt, hdr_cur;
  logic [15:0] crc_r, crc_nxt, crc_cur;
  logic [15:0] rcv_r, rcv_nxt, rcv_cur;
  logic [5:0]  plen_r, plen_nxt, plen_cur;
  logic        done_r, done_nxt, done_cur;
  logic        fire;

  logic [31:0] h;
  logic [1:0]  h_id, h_layer, h_sr, h_cm, h_ext;
  logic [3:0]  h_br;
  logic        h_bad, h_unk, p_known;
  logic [5:0]  p_len;

  assign in_tready = !q_full;
  assign fire      = in_tvalid && in_tready;

  // restart drops whatever the previous frame left behind
  assign pos_cur  = in_tuser ? 6'd0 : pos_r;
  assign hdr_cur  = in_tuser ? 32'd0 : hdr_r;
  assign crc_cur  = in_tuser ? CRC_INIT : crc_r;
  assign rcv_cur  = in_tuser ? 16'd0 : rcv_r;
  assign plen_cur = in_tuser ? 6'd0 : plen_r;
  assign done_cur = in_tuser ? 1'b0 : done_r;

  // header as it stands once the fourth byte is shifted in
  assign h       = {hdr_cur[23:0], in_tdata};
  assign h_id    = h[20:19];
  assign h_layer = h[18:17];
  assign h_br    = h[15:12];
  assign h_sr    = h[11:10];
  assign h_cm    = h[7:6];
  assign h_ext   = h[5:4];
  assign h_bad   = (h[31:21] != 11'h7FF) || (h_br == 4'hF);
  assign h_unk   = (h_id == 2'd1) || (h_layer == 2'd0) || (h_br == 4'd0) || (h_sr == 2'd3);

  always_comb begin
    p_known = 1'b0;
    p_len   = 6'd0;
    if (h_layer == 2'd3) begin
      p_known = 1'b1;
      if (h_cm == 2'd3) begin
        p_len = 6'd22;
      end else if (h_cm == 2'd1) begin
        p_len = 6'd24 + {3'b000, h_ext, 1'b0};
      end else begin
        p_len = 6'd38;
      end
    end else if (h_layer == 2'd1 && h_id != 2'd1) begin
      p_known = 1'b1;
      if (h_id == 2'd3 && h_cm != 2'd3) begin
        p_len = 6'd38;
      end else if (h_id != 2'd3 && h_cm == 2'd3) begin
        p_len = 6'd15;
      end else begin
        p_len = 6'd23;
      end
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    hdr_nxt  = hdr_r;
    crc_nxt  = crc_r;
    rcv_nxt  = rcv_r;
    plen_nxt = plen_r;
    done_nxt = done_r;
    q_push   = 1'b0;
    q_entry  = '{kind: KIND_PLAIN, status: ST_NO_CRC, prot_len: 6'd0, crc: 16'd0,
                 header: h};
    if (fire) begin
      pos_nxt  = pos_cur;
      hdr_nxt  = hdr_cur;
      crc_nxt  = crc_cur;
      rcv_nxt  = rcv_cur;
      plen_nxt = plen_cur;
      done_nxt = done_cur;
      if (!done_cur) begin
        pos_nxt = pos_cur + 6'd1;
        if (pos_cur < 6'd4) begin
          hdr_nxt = h;
          if (pos_cur >= 6'd2) begin
            crc_nxt = crc_byte(crc_cur, in_tdata);
          end
          if (pos_cur == 6'd3) begin
            q_push   = 1'b1;
            done_nxt = 1'b1;
            if (h_bad) begin
              q_entry.status = ST_BAD_HDR;
            end else if (h_unk) begin
              q_entry.status = ST_SIZE_UNK;
            end else if (!crc_en || h[16]) begin
              q_entry.kind   = KIND_LEN_EMIT;
              q_entry.status = ST_NO_CRC;
            end else if (!p_known) begin
              q_entry.kind   = KIND_LEN_EMIT;
              q_entry.status = ST_PROT_UNK;
            end else begin
              q_entry.kind = KIND_LEN;
              plen_nxt     = p_len;
              done_nxt     = 1'b0;
            end
          end
        end else begin
          if (pos_cur < 6'd6) begin
            rcv_nxt = {rcv_cur[7:0], in_tdata};
          end else begin
            crc_nxt = crc_byte(crc_cur, in_tdata);
          end
          if ({1'b0, pos_cur} + 7'd1 >= {1'b0, plen_cur}) begin
            q_push           = 1'b1;
            done_nxt         = 1'b1;
            q_entry.kind     = KIND_CRC;
            q_entry.status   = (crc_nxt == rcv_nxt) ? ST_CRC_OK : ST_CRC_BAD;
            q_entry.prot_len = plen_cur;
            q_entry.crc      = crc_nxt;
            q_entry.header   = hdr_cur;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= 6'd0;
      hdr_r  <= 32'd0;
      crc_r  <= CRC_INIT;
      rcv_r  <= 16'd0;
      plen_r <= 6'd0;
      done_r <= 1'b1;
    end else begin
      pos_r  <= pos_nxt;
      hdr_r  <= hdr_nxt;
      crc_r  <= crc_nxt;
      rcv_r  <= rcv_nxt;
      plen_r <= plen_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

// ===== rtl/core/mahc_fifo.sv =====
module mahc_fifo (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mahc_pkg::mahc_entry_t push_entry,
  input  logic                  pop,
  output logic                  full,
  output logic                  valid,
  output mahc_pkg::mahc_entry_t head
);
  import mahc_pkg::*;

  // two slots, slot 0 is always the head
  mahc_entry_t slot0_r, slot1_r;
  logic [1:0]  cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = slot0_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt_r == 2'd2) begin
        slot0_r <= slot1_r;
        if (push) begin
          slot1_r <= push_entry;
        end
      end else if (push) begin
        slot0_r <= push_entry;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_r <= push_entry;
      end else begin
        slot1_r <= push_entry;
      end
    end
  end

endmodule

// ===== rtl/core/mahc_back.sv =====
module mahc_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  mahc_pkg::mahc_entry_t q_head,
  output logic                  q_pop,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [71:0]           out_tdata
);
  import mahc_pkg::*;

  // kbit/s divided by 8: [version bit 0][layer - 1][bitrate index - 1]
  localparam logic [5:0] RATE_TAB [84] = '{
    6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd18, 6'd20,
    6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd18, 6'd20,
    6'd4, 6'd6, 6'd7, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd18, 6'd20, 6'd22, 6'd24, 6'd28,
    6'd32,
    6'd4, 6'd5, 6'd6, 6'd7, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd20, 6'd24, 6'd28, 6'd32,
    6'd40,
    6'd4, 6'd6, 6'd7, 6'd8, 6'd10, 6'd12, 6'd14, 6'd16, 6'd20, 6'd24, 6'd28, 6'd32, 6'd40,
    6'd48,
    6'd4, 6'd8, 6'd12, 6'd16, 6'd20, 6'd24, 6'd28, 6'd32, 6'd36, 6'd40, 6'd44, 6'd48, 6'd52,
    6'd56
  };

  // floor(2^32 / base) for the three sampling-rate bases
  localparam logic [23:0] RECIP_441 = 24'd9739154;
  localparam logic [23:0] RECIP_480 = 24'd8947848;
  localparam logic [23:0] RECIP_320 = 24'd13421772;

  mahc_bk_state_t state_r, state_nxt;
  mahc_entry_t    wk_r;
  logic [21:0]    num_r;
  logic [13:0]    qest_r;
  logic [11:0]    flen_r;
  logic           ld_num, ld_q, ld_len, emit;

  logic           out_tvalid_r;
  logic [71:0]    out_tdata_r;

  logic [1:0]  id, layer, sr;
  logic [3:0]  br;
  logic [1:0]  shift_c;
  logic [7:0]  spf8_c;
  logic [8:0]  base_c;
  logic [23:0] recip_c;
  logic [2:0]  pad_c;
  logic [6:0]  rt_idx;
  logic [13:0] m_c;
  logic [21:0] num_c;
  logic [45:0] prod_c;
  logic [22:0] qd_c;
  logic [21:0] rem_c;
  logic [13:0] q_c, qs_c;
  logic [11:0] flen_c;
  logic [11:0] out_fb;

  assign id    = wk_r.header[20:19];
  assign layer = wk_r.header[18:17];
  assign br    = wk_r.header[15:12];
  assign sr    = wk_r.header[11:10];

  always_comb begin
    case (id)
      2'd3:    shift_c = 2'd2;
      2'd2:    shift_c = 2'd1;
      default: shift_c = 2'd0;
    endcase
    case (sr)
      2'd1: begin
        base_c  = 9'd480;
        recip_c = RECIP_480;
      end
      2'd2: begin
        base_c  = 9'd320;
        recip_c = RECIP_320;
      end
      default: begin
        base_c  = 9'd441;
        recip_c = RECIP_441;
      end
    endcase
    if (layer == 2'd3) begin
      spf8_c = 8'd48;
    end else if (layer == 2'd2 || id == 2'd3) begin
      spf8_c = 8'd144;
    end else begin
      spf8_c = 8'd72;
    end
    if (!wk_r.header[9]) begin
      pad_c = 3'd0;
    end else if (layer == 2'd3) begin
      pad_c = 3'd4;
    end else begin
      pad_c = 3'd1;
    end
    case (layer)
      2'd2:    rt_idx = 7'd14;
      2'd3:    rt_idx = 7'd28;
      default: rt_idx = 7'd0;
    endcase
    rt_idx = rt_idx + (id[0] ? 7'd42 : 7'd0) + {3'b000, br - 4'd1};
  end

  // numerator = samples/8 * bitrate/8 * 320, divided by base then by 2^shift
  assign m_c    = 14'(spf8_c) * 14'(RATE_TAB[rt_idx]);
  assign num_c  = {m_c, 8'd0} + {2'b00, m_c, 6'd0};
  assign prod_c = 46'(num_r) * 46'(recip_c);
  assign qd_c   = 23'(qest_r) * 23'(base_c);
  assign rem_c  = num_r - qd_c[21:0];
  assign q_c    = qest_r + 14'(rem_c >= 22'(base_c));
  assign qs_c   = q_c >> shift_c;
  assign flen_c = qs_c[11:0] + 12'(pad_c);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: begin
        if (q_valid) begin
          if (q_head.kind == KIND_PLAIN || q_head.kind == KIND_CRC) begin
            state_nxt = BK_EMIT;
          end else begin
            state_nxt = BK_NUM;
          end
        end
      end
      BK_NUM:  state_nxt = BK_PROD;
      BK_PROD: state_nxt = BK_FIX;
      BK_FIX:  state_nxt = (wk_r.kind == KIND_LEN) ? BK_IDLE : BK_EMIT;
      BK_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop  = (state_r == BK_IDLE) && q_valid;
    ld_num = (state_r == BK_NUM);
    ld_q   = (state_r == BK_PROD);
    ld_len = (state_r == BK_FIX);
    emit   = (state_r == BK_EMIT) && (!out_tvalid_r || out_tready);
  end

  assign out_fb = (wk_r.kind == KIND_PLAIN) ? 12'd0 : flen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      wk_r <= q_head;
    end
    if (ld_num) begin
      num_r <= num_c;
    end
    if (ld_q) begin
      qest_r <= prod_c[45:32];
    end
    if (ld_len) begin
      flen_r <= flen_c;
    end
    if (emit) begin
      out_tdata_r <= {3'b000, wk_r.header, wk_r.crc, wk_r.prot_len, out_fb, wk_r.status};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
